>>> hdl/kcf_pkg.sv
package kcf_pkg;

   localparam int BASE_W      = 2;
   localparam int PATTERN_W   = 16;
   localparam int KLEN_W      = 4;
   localparam int WLEN_W      = 10;
   localparam int THR_W       = 10;
   localparam int COUNT_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int EPOCH_W     = 4;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 10'd512;
   localparam logic [THR_W-1:0]  THR_RESET  = 10'd3;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KMER_LENGTH   = 2'd0,
      CSR_WINDOW_LENGTH = 2'd1,
      CSR_THRESHOLD     = 2'd2
   } csr_index_type;

   typedef enum logic {
      TBL_CLEAR,
      TBL_RUN
   } tbl_state_type;

   typedef struct packed {
      logic valid;
      logic start;
      logic lv_ok;
      logic en_ok;
   } item_flags_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic               mark;
      logic [COUNT_W-1:0] count;
   } tbl_entry_type;

endpackage

>>> hdl/kcf_if.sv
interface kcf_req_if import kcf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base;
   logic              start_req;

   modport source (output valid, base, start_req, input ready);
   modport sink (input valid, base, start_req, output ready);
endinterface

interface kcf_rsp_if import kcf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PATTERN_W-1:0] pattern;

   modport source (output valid, pattern, input ready);
   modport sink (input valid, pattern, output ready);
endinterface

interface kcf_csr_if import kcf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/kmer_clump_finder.sv
// Clump finder over a streamed genome, one base per input beat (A,C,G,T = 0..3). Each
// complete k-mer is counted into a table with one entry per code, the k-mer leaving the
// window is counted down, and a k-mer is reported once, on the beat where its count first
// reaches the threshold. No base is taken while the last one sits in the first stage, as
// the count table's single read port serves two read-modify-writes for every base: a
// decrement and an increment. A result passes the front stage, table stages s2 and s3
// and a four-entry queue, so a stalled output stops input only once all its slots are reserved.
// After reset all 4**KMER_MAX table entries (65536 at the default) are swept before the
// first base is taken. start_req clears the table by advancing a four-bit epoch; on the
// sixteenth genome start after a sweep the epoch runs out and another full sweep runs
// before that base is taken. Configuration must be written through the csr port only
// while no base is in flight; the block itself does not enforce it.
module kmer_clump_finder import kcf_pkg::*; #(
   parameter int KMER_MAX   = 8,
   parameter int WINDOW_MAX = 512
) (
   input logic       clock,
   input logic       reset,
   kcf_req_if.sink   req_if,
   kcf_rsp_if.source rsp_if,
   kcf_csr_if.sink   csr_if
);

   localparam int CODE_W = 2*KMER_MAX;
   localparam int MW     = CODE_W+1;
   localparam int EXT_W  = (CODE_W > PATTERN_W) ? CODE_W : PATTERN_W;
   localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(KMER_MAX);

   logic [KLEN_W-1:0] klen_ff, klen_in, k_eff;
   logic [WLEN_W-1:0] wlen_ff, wlen_in, len_eff;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [MW-1:0]     mask_wide;
   logic [CODE_W-1:0] mask;

   item_flags_type    s1_flags;
   logic [CODE_W-1:0] s1_code, hist_q, res_code;
   logic [EXT_W-1:0]  code_ext;
   logic              accept, res_valid, done, tbl_busy, epoch_last, pipe_busy;
   logic              room, sweep_req;

   always_comb begin
      klen_in = klen_ff;
      wlen_in = wlen_ff;
      thr_in  = thr_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_KMER_LENGTH:   klen_in = csr_if.data[KLEN_W-1:0];
            CSR_WINDOW_LENGTH: wlen_in = csr_if.data[WLEN_W-1:0];
            CSR_THRESHOLD:     thr_in  = csr_if.data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= KLEN_RESET;
         wlen_ff <= WLEN_RESET;
         thr_ff  <= THR_RESET;
      end else begin
         klen_ff <= klen_in;
         wlen_ff <= wlen_in;
         thr_ff  <= thr_in;
      end
   end

   always_comb begin
      if (klen_ff == '0) begin
         k_eff = KLEN_W'(1);
      end else if (klen_ff > KLEN_MAX) begin
         k_eff = KLEN_MAX;
      end else begin
         k_eff = klen_ff;
      end
      if (32'(wlen_ff) > 32'(WINDOW_MAX)) begin
         len_eff = WLEN_W'(WINDOW_MAX);
      end else begin
         len_eff = wlen_ff;
      end
      mask_wide = (MW'(1) << {k_eff, 1'b0}) - MW'(1);
      mask      = mask_wide[CODE_W-1:0];
   end

   // a start beat that would wrap the epoch waits for the sweep it triggers
   assign req_if.ready = !tbl_busy && !s1_flags.valid && room
                         && !(req_if.start_req && epoch_last);
   assign accept       = req_if.valid && req_if.ready;
   assign sweep_req    = req_if.valid && req_if.start_req && epoch_last
                         && !s1_flags.valid && !pipe_busy;
   assign csr_if.ready = 1'b1;

   kcf_front #(
      .KMER_MAX   (KMER_MAX),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .base      (req_if.base),
      .start_req (req_if.start_req),
      .k_eff     (k_eff),
      .len_eff   (len_eff),
      .mask      (mask),
      .s1_flags  (s1_flags),
      .s1_code   (s1_code),
      .hist_q    (hist_q)
   );

   kcf_table #(
      .KMER_MAX (KMER_MAX)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .s1_flags   (s1_flags),
      .s1_code    (s1_code),
      .hist_q     (hist_q),
      .mask       (mask),
      .threshold  (thr_ff),
      .sweep_req  (sweep_req),
      .res_valid  (res_valid),
      .res_code   (res_code),
      .done       (done),
      .busy       (tbl_busy),
      .epoch_last (epoch_last),
      .pipe_busy  (pipe_busy)
   );

   assign code_ext = EXT_W'(res_code);

   kcf_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .reserve      (accept),
      .release_slot (done && !res_valid),
      .push         (res_valid),
      .push_data    (code_ext[PATTERN_W-1:0]),
      .room         (room),
      .out_valid    (rsp_if.valid),
      .out_ready    (rsp_if.ready),
      .out_pattern  (rsp_if.pattern)
   );

endmodule

>>> hdl/kcf_front.sv
module kcf_front import kcf_pkg::*; #(
   parameter int KMER_MAX   = 8,
   parameter int WINDOW_MAX = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [BASE_W-1:0]       base,
   input  logic                    start_req,
   input  logic [KLEN_W-1:0]       k_eff,
   input  logic [WLEN_W-1:0]       len_eff,
   input  logic [2*KMER_MAX-1:0]   mask,
   output item_flags_type          s1_flags,
   output logic [2*KMER_MAX-1:0]   s1_code,
   output logic [2*KMER_MAX-1:0]   hist_q
);

   localparam int CODE_W = 2*KMER_MAX;
   localparam int AW     = $clog2(WINDOW_MAX);
   localparam int HW     = $clog2(WINDOW_MAX+1);
   localparam int SW     = AW+1;

   // each history entry holds the unmasked code of the last KMER_MAX bases
   logic [CODE_W-1:0] hist_mem [WINDOW_MAX];
   logic [CODE_W-1:0] hist_q_ff;

   logic [AW-1:0]     wp_ff, wp_in, wp_cur, rd_addr;
   logic [WLEN_W-1:0] seen_ff, seen_in, seen_cur;
   logic [CODE_W-1:0] ent_ff, ent_in, ent_cur;
   logic [CODE_W-1:0] roll_ff, roll_in, roll_cur;
   logic [CODE_W-1:0] s1_code_ff;
   item_flags_type    s1_flags_ff, s1_flags_in;

   logic              full, len_ok;
   logic [HW-1:0]     back_dist;
   logic [SW-1:0]     diff;

   always_comb begin
      wp_cur   = start_req ? '0 : wp_ff;
      seen_cur = start_req ? '0 : seen_ff;
      ent_cur  = start_req ? '0 : ent_ff;
      roll_cur = start_req ? '0 : roll_ff;

      full   = (seen_cur >= len_eff);
      len_ok = (len_eff >= WLEN_W'(k_eff));

      roll_in = (roll_cur << 2) | CODE_W'(base);
      ent_in  = ((ent_cur << 2) | CODE_W'(base)) & mask;
      seen_in = (seen_cur < len_eff) ? seen_cur + WLEN_W'(1) : seen_cur;
      wp_in   = (wp_cur == AW'(WINDOW_MAX-1)) ? '0 : wp_cur + AW'(1);

      // newest base of the leaving k-mer sits len-k+1 beats back
      back_dist = HW'(len_eff - WLEN_W'(k_eff) + WLEN_W'(1));
      diff      = SW'(wp_cur) - SW'(back_dist);
      if (SW'(wp_cur) < SW'(back_dist)) begin
         rd_addr = AW'(diff + SW'(WINDOW_MAX));
      end else begin
         rd_addr = AW'(diff);
      end

      s1_flags_in.valid = accept;
      s1_flags_in.start = start_req;
      s1_flags_in.lv_ok = len_ok && full;
      s1_flags_in.en_ok = len_ok && (full || (seen_in >= WLEN_W'(k_eff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         seen_ff     <= '0;
         ent_ff      <= '0;
         roll_ff     <= '0;
         s1_flags_ff <= '0;
      end else begin
         s1_flags_ff <= s1_flags_in;
         if (accept) begin
            wp_ff   <= wp_in;
            seen_ff <= seen_in;
            ent_ff  <= ent_in;
            roll_ff <= roll_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_code_ff <= ent_in;
      end
   end

   // read sees the old entry when it hits the slot being written
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wp_cur] <= roll_in;
      end
      hist_q_ff <= hist_mem[rd_addr];
   end

   assign s1_flags = s1_flags_ff;
   assign s1_code  = s1_code_ff;
   assign hist_q   = hist_q_ff;

endmodule

>>> hdl/kcf_table.sv
module kcf_table import kcf_pkg::*; #(
   parameter int KMER_MAX = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  item_flags_type        s1_flags,
   input  logic [2*KMER_MAX-1:0] s1_code,
   input  logic [2*KMER_MAX-1:0] hist_q,
   input  logic [2*KMER_MAX-1:0] mask,
   input  logic [THR_W-1:0]      threshold,
   input  logic                  sweep_req,
   output logic                  res_valid,
   output logic [2*KMER_MAX-1:0] res_code,
   output logic                  done,
   output logic                  busy,
   output logic                  epoch_last,
   output logic                  pipe_busy
);

   localparam int CODE_W = 2*KMER_MAX;
   localparam int DEPTH  = 1 << CODE_W;

   tbl_entry_type mem [DEPTH];
   tbl_entry_type rd_q_ff, fwd_data_ff, raw, wr_data;
   logic          fwd_hit_ff;

   tbl_state_type state_ff, state_in;
   logic [CODE_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in, item_tag;

   item_flags_type     s2_flags_ff, s3_flags_ff;
   logic [EPOCH_W-1:0] s2_tag_ff, s3_tag_ff, cur_tag;
   logic [CODE_W-1:0]  s2_lv_code_ff, s2_ent_code_ff, s3_code_ff;

   logic [CODE_W-1:0]  rd_addr, wr_addr;
   logic               wr_en;
   logic               live, mark, hit;
   logic [COUNT_W-1:0] cnt, cnt_dec, cnt_inc;

   // read port: leaving code while the item is in s1, entering code while it is in s2
   always_comb begin
      rd_addr  = s1_flags.valid ? (hist_q & mask) : s2_ent_code_ff;
      item_tag = s1_flags.start ? epoch_ff + EPOCH_W'(1) : epoch_ff;
   end

   // entries written under an older epoch read as cleared
   always_comb begin
      raw     = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
      cur_tag = s2_flags_ff.valid ? s2_tag_ff : s3_tag_ff;
      live    = (raw.tag == cur_tag);
      cnt     = live ? raw.count : '0;
      mark    = live && raw.mark;
      cnt_dec = (cnt != '0) ? cnt - COUNT_W'(1) : cnt;
      cnt_inc = (cnt != COUNT_LIMIT) ? cnt + COUNT_W'(1) : cnt;
      hit     = (cnt_inc >= threshold) && !mark;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TBL_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = TBL_RUN;
            end
         end
         TBL_RUN: begin
            if (sweep_req) begin
               state_in = TBL_CLEAR;
            end
         end
         default: state_in = TBL_CLEAR;
      endcase
   end

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = s2_lv_code_ff;
      wr_data     = '0;
      clr_addr_in = clr_addr_ff;
      epoch_in    = s1_flags.valid ? item_tag : epoch_ff;
      case (state_ff)
         TBL_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + CODE_W'(1);
            epoch_in    = '0;
         end
         TBL_RUN: begin
            if (s2_flags_ff.valid && s2_flags_ff.lv_ok) begin
               wr_en         = 1'b1;
               wr_addr       = s2_lv_code_ff;
               wr_data.tag   = s2_tag_ff;
               wr_data.mark  = mark;
               wr_data.count = cnt_dec;
            end else if (s3_flags_ff.valid && s3_flags_ff.en_ok) begin
               wr_en         = 1'b1;
               wr_addr       = s3_code_ff;
               wr_data.tag   = s3_tag_ff;
               wr_data.mark  = mark || hit;
               wr_data.count = cnt_inc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= TBL_CLEAR;
         clr_addr_ff <= '0;
         epoch_ff    <= '0;
         s2_flags_ff <= '0;
         s3_flags_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         epoch_ff    <= epoch_in;
         s2_flags_ff <= s1_flags;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_tag_ff      <= item_tag;
      s2_lv_code_ff  <= hist_q & mask;
      s2_ent_code_ff <= s1_code;
      s3_tag_ff      <= s2_tag_ff;
      s3_code_ff     <= s2_ent_code_ff;
      // a same-beat write to the entry being read bypasses the array
      fwd_hit_ff     <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff    <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign res_valid  = s3_flags_ff.valid && s3_flags_ff.en_ok && hit;
   assign res_code   = s3_code_ff;
   assign done       = s3_flags_ff.valid;
   assign busy       = (state_ff == TBL_CLEAR);
   assign epoch_last = (epoch_ff == EPOCH_LAST);
   assign pipe_busy  = s2_flags_ff.valid || s3_flags_ff.valid;

endmodule

>>> hdl/kcf_rsp_queue.sv
module kcf_rsp_queue import kcf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 reserve,
   input  logic                 release_slot,
   input  logic                 push,
   input  logic [PATTERN_W-1:0] push_data,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [PATTERN_W-1:0] out_pattern
);

   logic [PATTERN_W-1:0] q_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] fill_ff, fill_in, resv_ff, resv_in;
   logic                 pop;

   // a slot is reserved per item in flight and freed once it is known to give no result
   always_comb begin
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
      resv_in   = resv_ff + RSP_CNT_W'(reserve) - RSP_CNT_W'(release_slot)
                  - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         resv_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         resv_ff   <= resv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign room        = (resv_ff < RSP_CNT_W'(RSP_DEPTH));
   assign out_valid   = (fill_ff != '0);
   assign out_pattern = q_mem[rd_ptr_ff];

endmodule
